// File: rtl/beat_rate_outlier_filter_macros.svh
// assertion macros shared by the beat rate outlier filter modules
`ifndef BEAT_RATE_OUTLIER_FILTER_MACROS_SVH
`define BEAT_RATE_OUTLIER_FILTER_MACROS_SVH

// same-cycle implication, checked while out of reset
`define BROF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define BROF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/brof_pkg.sv
// types, constants and widths shared by the beat rate outlier filter
package brof_pkg;

  localparam int RATE_FRACTION_BITS = 8;
  localparam int RATE_W = 20;
  localparam int TIME_W = 32;
  localparam int SR_W = 16;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int IN_TDATA_W = 32;
  localparam int OUT_TDATA_W = 56;
  localparam int KIND_W = 2;

  localparam int SECONDS_PER_MINUTE = 60;

  // dividend is sample_rate*60 scaled, plus half the interval
  localparam int NUM_W = SR_W + 6 + RATE_FRACTION_BITS;
  localparam int DIV_W = ((NUM_W > TIME_W - 1) ? NUM_W : TIME_W - 1) + 1;
  localparam int CNT_W = $clog2(DIV_W + 1);

  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
  localparam longint MEAN_FULL = longint'(70) << RATE_FRACTION_BITS;
  localparam logic [RATE_W-1:0] MEAN_RESET =
    (MEAN_FULL > longint'(RATE_MAX)) ? RATE_MAX : RATE_W'(MEAN_FULL);

  // divide by ten as multiply by ceil(2^25/10), exact below 2^22
  localparam int RECIP_SHIFT = 25;
  localparam int RECIP_W = 22;
  localparam logic [RECIP_W-1:0] RECIP_TEN = RECIP_W'(3355444);
  localparam logic [RATE_W:0] ROUND_TEN = (RATE_W+1)'(5);
  localparam int PROD_W = RATE_W + 1 + RECIP_W;
  localparam int STEP_W = PROD_W - RECIP_SHIFT;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_RATE  = 3'd0,
    REG_TOLERANCE    = 3'd1,
    REG_EXCLUDE_MODE = 3'd2,
    REG_STOP_TIME    = 3'd3
  } cfg_reg_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE     = 2'd0,
    KIND_NORMAL   = 2'd1,
    KIND_ABNORMAL = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DIFF,
    ST_MULT,
    ST_UPDATE,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic capture;
    logic set_stop;
    logic mark_abnormal;
    logic div_start;
    logic latch_rate;
    logic calc_diff;
    logic calc_mult;
    logic update_mean;
    logic commit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic  stopped;
    logic  past_stop;
    kind_t kind;
    logic  div_busy;
    logic  emit_wanted;
    logic  out_busy;
  } status_t;

endpackage

// File: rtl/brof_divider.sv
// restoring divider, one quotient bit per cycle
`include "beat_rate_outlier_filter_macros.svh"

module brof_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [brof_pkg::DIV_W-1:0] dividend,
  input  logic [brof_pkg::TIME_W-1:0] divisor,
  output logic                       busy,
  output logic [brof_pkg::DIV_W-1:0] quotient
);
  import brof_pkg::*;

  logic [CNT_W-1:0]  count;
  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] dsor;
  logic [TIME_W:0]   shifted;
  logic [TIME_W+1:0] trial;

  assign busy = (count != '0);
  assign shifted = {rem, quotient[DIV_W-1]};
  assign trial = {1'b0, shifted} - {2'b00, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_W'(DIV_W);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsor <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      // a zero divisor never borrows, so the quotient fills with ones
      if (!trial[TIME_W+1]) begin
        rem <= trial[TIME_W-1:0];
        quotient <= {quotient[DIV_W-2:0], 1'b1};
      end else begin
        rem <= shifted[TIME_W-1:0];
        quotient <= {quotient[DIV_W-2:0], 1'b0};
      end
    end
  end

  `BROF_ASSERT_NEXT(div_count_down, busy && !start, count == $past(count) - 1'b1,
                    "divider count did not step")

endmodule

// File: rtl/brof_datapath.sv
// datapath: configuration, filter state, rate division, mean update, output register
`include "beat_rate_outlier_filter_macros.svh"

module brof_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  brof_pkg::cmd_t                cmd,
  output brof_pkg::status_t             status,
  input  logic                          cfg_we,
  input  logic [brof_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brof_pkg::CFG_W-1:0]    cfg_data,
  input  logic [brof_pkg::IN_TDATA_W-1:0] s_tdata,
  input  logic [brof_pkg::KIND_W-1:0]   s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [brof_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                          m_tuser
);
  import brof_pkg::*;

  logic [SR_W-1:0]   sample_rate;
  logic [RATE_W-1:0] tolerance;
  logic              exclude_mode;
  logic [TIME_W-1:0] stop_time;

  logic [TIME_W-1:0] previous_time;
  logic [RATE_W-1:0] previous_rate;
  logic [RATE_W-1:0] mean_rate;
  logic              previous_was_normal;
  logic              previous_rejected;
  logic              stopped;

  kind_t             in_kind;
  logic [TIME_W-1:0] in_time;
  logic [RATE_W-1:0] rate;
  logic [RATE_W:0]   diff5;
  logic              rate_up;
  logic [PROD_W-1:0] product;

  logic [TIME_W-1:0] out_start;
  logic [RATE_W-1:0] out_rate;
  logic              out_flag;

  logic [TIME_W-1:0] interval;
  logic [DIV_W-1:0]  dividend;
  logic              div_busy;
  logic [DIV_W-1:0]  quotient;
  logic [STEP_W-1:0] step;
  logic [RATE_W-1:0] diff_prev;
  logic [RATE_W-1:0] diff_mean;
  logic              accept_ok;

  assign interval = in_time - previous_time;
  assign dividend = ((DIV_W'(sample_rate) * DIV_W'(SECONDS_PER_MINUTE)) << RATE_FRACTION_BITS)
                    + DIV_W'(interval >> 1);

  brof_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (interval),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign step = product[PROD_W-1:RECIP_SHIFT];
  assign diff_prev = (rate >= previous_rate) ? rate - previous_rate : previous_rate - rate;
  assign diff_mean = (rate >= mean_rate) ? rate - mean_rate : mean_rate - rate;
  assign accept_ok = previous_was_normal && (diff_prev < tolerance) && (diff_mean < tolerance);

  assign status.stopped = stopped;
  assign status.past_stop = (stop_time != '0) && (in_time > stop_time);
  assign status.kind = in_kind;
  assign status.div_busy = div_busy;
  assign status.emit_wanted = accept_ok && (!exclude_mode || !previous_rejected);
  assign status.out_busy = m_tvalid && !m_tready;

  assign m_tdata = {(OUT_TDATA_W - TIME_W - RATE_W)'(0), out_rate, out_start};
  assign m_tuser = out_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= SR_W'(250);
      tolerance <= RATE_W'(2560);
      exclude_mode <= 1'b0;
      stop_time <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_RATE:  sample_rate <= cfg_data[SR_W-1:0];
        REG_TOLERANCE:    tolerance <= cfg_data[RATE_W-1:0];
        REG_EXCLUDE_MODE: exclude_mode <= cfg_data[0];
        REG_STOP_TIME:    stop_time <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_time <= '0;
      previous_rate <= '0;
      mean_rate <= MEAN_RESET;
      previous_was_normal <= 1'b0;
      previous_rejected <= 1'b1;
      stopped <= 1'b0;
    end else begin
      if (cmd.set_stop) begin
        stopped <= 1'b1;
      end
      if (cmd.mark_abnormal) begin
        previous_rejected <= 1'b1;
        previous_was_normal <= 1'b0;
      end
      if (cmd.update_mean) begin
        mean_rate <= rate_up ? mean_rate + RATE_W'(step) : mean_rate - RATE_W'(step);
      end
      if (cmd.commit) begin
        previous_rejected <= !accept_ok;
        previous_was_normal <= 1'b1;
        previous_time <= in_time;
        previous_rate <= rate;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_kind <= kind_t'(s_tuser);
      in_time <= s_tdata[TIME_W-1:0];
    end
    if (cmd.latch_rate) begin
      rate <= (quotient > DIV_W'(RATE_MAX)) ? RATE_MAX : quotient[RATE_W-1:0];
    end
    if (cmd.calc_diff) begin
      rate_up <= (rate >= mean_rate);
      diff5 <= ((rate >= mean_rate) ? {1'b0, rate - mean_rate} : {1'b0, mean_rate - rate})
               + ROUND_TEN;
    end
    if (cmd.calc_mult) begin
      product <= PROD_W'(diff5) * PROD_W'(RECIP_TEN);
    end
  end

  // output register: a finished result waits here while the next item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_start <= previous_time;
      out_rate <= rate;
      out_flag <= !exclude_mode && previous_rejected;
    end
  end

  `BROF_ASSERT_IMPL(emit_no_overwrite, cmd.emit, !(m_tvalid && !m_tready),
                    "result emitted over one not yet transferred")
  `BROF_ASSERT_NEXT(mean_moves_toward_rate, cmd.update_mean,
                    (mean_rate >= $past(mean_rate) && mean_rate <= $past(rate)) ||
                    (mean_rate <= $past(mean_rate) && mean_rate >= $past(rate)),
                    "mean left the range between old mean and rate")

endmodule

// File: rtl/brof_ctrl.sv
// controller state machine sequencing one event through the datapath
`include "beat_rate_outlier_filter_macros.svh"

module brof_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  brof_pkg::status_t status,
  output brof_pkg::cmd_t    cmd
);
  import brof_pkg::*;

  state_t state;
  state_t state_next;
  logic   stall;

  // a result that must go out waits for the output register to free up
  assign stall = status.emit_wanted && status.out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (!status.stopped && !status.past_stop && status.kind == KIND_NORMAL) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (!status.div_busy) state_next = ST_DIFF;
      end
      ST_DIFF:   state_next = ST_MULT;
      ST_MULT:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (!stall) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.capture = s_tvalid;
      end
      ST_CHECK: begin
        if (!status.stopped) begin
          if (status.past_stop) begin
            cmd.set_stop = 1'b1;
          end else if (status.kind == KIND_ABNORMAL) begin
            cmd.mark_abnormal = 1'b1;
          end else if (status.kind == KIND_NORMAL) begin
            cmd.div_start = 1'b1;
          end
        end
      end
      ST_DIV:    cmd.latch_rate = !status.div_busy;
      ST_DIFF:   cmd.calc_diff = 1'b1;
      ST_MULT:   cmd.calc_mult = 1'b1;
      ST_UPDATE: cmd.update_mean = 1'b1;
      ST_DECIDE: begin
        cmd.commit = !stall;
        cmd.emit = status.emit_wanted && !status.out_busy;
      end
      default: ;
    endcase
  end

  `BROF_ASSERT_NEXT(div_held, state == ST_DIV && status.div_busy, state == ST_DIV,
                    "left the divide step while the divider was busy")
  `BROF_ASSERT_NEXT(stopped_skips, state == ST_CHECK && status.stopped, state == ST_IDLE,
                    "event processed after stop")

endmodule

// File: rtl/beat_rate_outlier_filter.sv
// top level of the beat rate outlier filter
// Takes beat events (tuser = kind, tdata = sample time) and emits, for accepted
// intervals between normal beats, the interval start time and the rate in
// unsigned Q12.8 bpm (tdata) with an after-reject flag (tuser). One item is
// handled at a time: a non-beat, abnormal beat or ignored event goes back to idle
// after ST_CHECK; a normal beat steps through ST_CHECK, ST_DIV (the restoring
// divider yields one quotient bit per cycle), ST_DIFF, ST_MULT, ST_UPDATE and
// ST_DECIDE, where a result to emit waits for the output register to free up. A
// pending result stays in the output register while the next event is taken.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must write
// it only while the block is idle, which the block itself does not enforce.
module beat_rate_outlier_filter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [brof_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [brof_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [brof_pkg::IN_TDATA_W-1:0]  s_tdata,  // [31:0] event_time
  input  logic [brof_pkg::KIND_W-1:0]      s_tuser,  // [1:0] kind
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [brof_pkg::OUT_TDATA_W-1:0] m_tdata,  // [31:0] interval_start, [51:32] beat_rate
  output logic                             m_tuser   // [0] after_reject
);
  import brof_pkg::*;

  cmd_t    cmd;
  status_t status;

  brof_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  brof_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
